/* hdl/pvm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PCM voice mixer package
// Opcodes, scaling constants and the control word of the shared scaler.
// ----------------------------------------------------------------------------
package pvm_pkg;

   localparam logic [3:0] OP_MIX       = 4'd0;
   localparam logic [3:0] OP_WRITE     = 4'd1;
   localparam logic [3:0] OP_LENGTH    = 4'd2;
   localparam logic [3:0] OP_ENABLE    = 4'd3;
   localparam logic [3:0] OP_PLAY      = 4'd4;
   localparam logic [3:0] OP_STOP      = 4'd5;
   localparam logic [3:0] OP_STOP_ALL  = 4'd6;
   localparam logic [3:0] OP_STRM_EN   = 4'd7;
   localparam logic [3:0] OP_STRM_PLAY = 4'd8;
   localparam logic [3:0] OP_STRM_STOP = 4'd9;
   localparam logic [3:0] OP_RESET     = 4'd10;

   localparam logic [7:0] GAIN_MAX   = 8'd200;
   localparam logic [7:0] GAIN_UNITY = 8'd100;
   localparam logic [6:0] NGAIN_MAX  = 7'd100;

   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // x / 100 == (x * RECIP_M) >> RECIP_SHIFT for x < 2**23
   localparam int MAG_W       = 24;
   localparam int PROD_W      = 2 * MAG_W;
   localparam int RECIP_SHIFT = 30;
   localparam logic [MAG_W-1:0] RECIP_M = 24'd10737419;
   localparam int TERM_W      = PROD_W - RECIP_SHIFT;

   typedef struct packed {
      logic run;
      logic recip;
   } scale_ctl_type;

endpackage

`default_nettype wire

/* hdl/pcm_voice_mixer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PCM voice mixer
// Opcode-driven mixer: clip memory, a pool of playback voices and one stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (valid/ready); rsp_* returns one result
//   word per command (valid/ready). csr_wen/csr_wdata writes native gain.
//   A mix word runs the native sample, each live voice and any taken stream
//   sample through one shared multiplier (sample*gain, then *1/100).
//   req_ready is high only while the sequencer is idle, so a new word is
//   accepted only after the previous result is registered.
//   The result register holds while rsp_ready is low; a following word is
//   accepted and processed, and waits for the register to drain.
//   Reset frees all voices, clears clip lengths and enables, stops the
//   stream and sets gains to 100. Clip sample memory is not cleared.
// ----------------------------------------------------------------------------
module pcm_voice_mixer #(
   parameter int NUM_CLIPS  = 16,
   parameter int NUM_VOICES = 8,
   parameter int CLIP_DEPTH = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_opcode,
   input  wire logic signed [15:0] req_native_sample,
   input  wire logic signed [15:0] req_stream_sample,
   input  wire logic               req_stream_valid,
   input  wire logic [4:0]         req_clip_id,
   input  wire logic [11:0]        req_sample_index,
   input  wire logic signed [15:0] req_clip_sample,
   input  wire logic [12:0]        req_clip_length,
   input  wire logic               req_flag,
   input  wire logic [7:0]         req_gain,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_mixed_sample,
   output logic                    rsp_accepted,
   input  wire logic               csr_wen,
   input  wire logic [6:0]         csr_wdata
);
   import pvm_pkg::*;

   localparam int CW        = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;
   localparam int VW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int PW        = $clog2(CLIP_DEPTH + 1);
   localparam int MEM_WORDS = NUM_CLIPS * CLIP_DEPTH;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int ACC_W     = TERM_W + $clog2(NUM_VOICES + 2);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_ACC    = 4'd4;
   localparam logic [3:0] S_VCHK   = 4'd5;
   localparam logic [3:0] S_VREAD  = 4'd6;
   localparam logic [3:0] S_STRM   = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;

   localparam logic [1:0] K_NATIVE = 2'd0;
   localparam logic [1:0] K_VOICE  = 2'd1;
   localparam logic [1:0] K_STREAM = 2'd2;

   logic [3:0]         state_ff;
   logic [1:0]         kind_ff;
   logic [VW-1:0]      vidx_ff;
   logic [6:0]         ngain_ff;
   logic [VW-1:0]      rptr_ff;
   logic               son_ff;
   logic               splay_ff;
   logic [7:0]         sgain_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_ok_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic               ok_ff;

   logic [3:0]         op_ff;
   logic signed [15:0] nsample_ff;
   logic signed [15:0] ssample_ff;
   logic               svalid_ff;
   logic [4:0]         id_ff;
   logic [11:0]        sidx_ff;
   logic signed [15:0] csample_ff;
   logic [12:0]        clen_ff;
   logic               flag_ff;
   logic [7:0]         gain_ff;

   logic signed [15:0] op_a_ff;
   logic [7:0]         op_g_ff;
   logic signed [15:0] mem_q_ff;

   logic [PW-1:0]      csize_ff [NUM_CLIPS];
   logic               con_ff   [NUM_CLIPS];
   logic [4:0]         vclip_ff [NUM_VOICES];
   logic [PW-1:0]      vpos_ff  [NUM_VOICES];
   logic [7:0]         vgain_ff [NUM_VOICES];
   logic               vloop_ff [NUM_VOICES];

   logic signed [15:0] clip_mem [MEM_WORDS];

   scale_ctl_type            sctl;
   logic signed [TERM_W-1:0] term;

   logic               req_id_ok;
   logic [CW-1:0]      req_cidx;
   logic               idx_ok;
   logic               len_ok;
   logic [7:0]         gain_sat;
   logic [4:0]         vid;
   logic               vid_ok;
   logic [4:0]         rd_id;
   logic [CW-1:0]      rd_cidx;
   logic [PW-1:0]      rd_size;
   logic               rd_on;
   logic [PW-1:0]      vpos;
   logic [PW-1:0]      vpos_inc;
   logic               vlive;
   logic [MEM_AW-1:0]  rd_addr;
   logic [MEM_AW-1:0]  wr_addr;
   logic               mem_we;
   logic               free_found;
   logic [VW-1:0]      free_slot;
   logic [VW-1:0]      play_slot;
   logic signed [ACC_W-1:0] term_ext;
   logic signed [15:0] sat_sample;

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;
   assign rsp_accepted     = rsp_ok_ff;

   assign req_id_ok = (id_ff != 5'd0) && (7'(id_ff) <= 7'(NUM_CLIPS));
   assign req_cidx  = CW'(7'(id_ff) - 7'd1);
   assign idx_ok    = 17'(sidx_ff) < 17'(CLIP_DEPTH);
   assign len_ok    = 17'(clen_ff) <= 17'(CLIP_DEPTH);
   assign gain_sat  = (gain_ff > GAIN_MAX) ? GAIN_MAX : gain_ff;

   assign vid      = vclip_ff[vidx_ff];
   assign vid_ok   = (vid != 5'd0) && (7'(vid) <= 7'(NUM_CLIPS));
   assign rd_id    = (state_ff == S_DECODE) ? id_ff : vid;
   assign rd_cidx  = CW'(7'(rd_id) - 7'd1);
   assign rd_size  = csize_ff[rd_cidx];
   assign rd_on    = con_ff[rd_cidx];
   assign vpos     = vpos_ff[vidx_ff];
   assign vpos_inc = vpos + PW'(1);
   assign vlive    = vid_ok && (rd_size != PW'(0)) && rd_on && (vpos < rd_size);

   assign rd_addr = MEM_AW'(rd_cidx) * MEM_AW'(CLIP_DEPTH) + MEM_AW'(vpos);
   assign wr_addr = MEM_AW'(req_cidx) * MEM_AW'(CLIP_DEPTH) + MEM_AW'(sidx_ff);
   assign mem_we  = (state_ff == S_DECODE) && (op_ff == OP_WRITE) && req_id_ok && idx_ok;

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int v = NUM_VOICES - 1; v >= 0; v--) begin
         if (vclip_ff[v] == 5'd0) begin
            free_found = 1'b1;
            free_slot  = VW'(v);
         end
      end
   end

   assign play_slot = free_found ? free_slot : rptr_ff;

   assign term_ext = {{(ACC_W - TERM_W){term[TERM_W-1]}}, term};

   always_comb begin
      if (acc_ff > ACC_W'(SAMPLE_MAX)) begin
         sat_sample = 16'(SAMPLE_MAX);
      end else if (acc_ff < ACC_W'(SAMPLE_MIN)) begin
         sat_sample = 16'(SAMPLE_MIN);
      end else begin
         sat_sample = 16'(acc_ff);
      end
   end

   assign sctl.run   = (state_ff == S_MUL) || (state_ff == S_DIV);
   assign sctl.recip = (state_ff == S_DIV);

   pvm_scale u_scale (
      .clock  (clock),
      .ctl    (sctl),
      .sample (op_a_ff),
      .gain   (op_g_ff),
      .term   (term)
   );

   // clip sample memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         clip_mem[wr_addr] <= csample_ff;
      end
      mem_q_ff <= clip_mem[rd_addr];
   end

   // latched command word
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff      <= req_opcode;
         nsample_ff <= req_native_sample;
         ssample_ff <= req_stream_sample;
         svalid_ff  <= req_stream_valid;
         id_ff      <= req_clip_id;
         sidx_ff    <= req_sample_index;
         csample_ff <= req_clip_sample;
         clen_ff    <= req_clip_length;
         flag_ff    <= req_flag;
         gain_ff    <= req_gain;
      end
   end

   // sequencer and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_NATIVE;
         vidx_ff      <= '0;
         ngain_ff     <= NGAIN_MAX;
         rptr_ff      <= '0;
         son_ff       <= 1'b0;
         splay_ff     <= 1'b0;
         sgain_ff     <= GAIN_UNITY;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CLIPS; c++) begin
            csize_ff[c] <= '0;
            con_ff[c]   <= 1'b0;
         end
         for (int v = 0; v < NUM_VOICES; v++) begin
            vclip_ff[v] <= '0;
            vpos_ff[v]  <= '0;
            vgain_ff[v] <= GAIN_UNITY;
            vloop_ff[v] <= 1'b0;
         end
      end else begin
         if (csr_wen && (csr_wdata <= NGAIN_MAX)) begin
            ngain_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               acc_ff   <= '0;
               state_ff <= (op_ff == OP_MIX) ? S_MUL : S_OUT;
               case (op_ff)
                  OP_MIX: begin
                     ok_ff   <= 1'b1;
                     op_a_ff <= nsample_ff;
                     op_g_ff <= 8'(ngain_ff);
                     kind_ff <= K_NATIVE;
                  end
                  OP_WRITE: begin
                     ok_ff <= req_id_ok && idx_ok;
                  end
                  OP_LENGTH: begin
                     ok_ff <= req_id_ok && len_ok;
                     if (req_id_ok && len_ok) begin
                        csize_ff[req_cidx] <= PW'(clen_ff);
                     end
                  end
                  OP_ENABLE: begin
                     ok_ff <= req_id_ok && (rd_size != PW'(0));
                     if (req_id_ok && (rd_size != PW'(0))) begin
                        con_ff[req_cidx] <= flag_ff;
                        for (int v = 0; v < NUM_VOICES; v++) begin
                           if (!flag_ff && (vclip_ff[v] == id_ff)) begin
                              vclip_ff[v] <= '0;
                              vpos_ff[v]  <= '0;
                              vgain_ff[v] <= GAIN_UNITY;
                              vloop_ff[v] <= 1'b0;
                           end
                        end
                     end
                  end
                  OP_PLAY: begin
                     ok_ff <= req_id_ok && (rd_size != PW'(0)) && rd_on;
                     if (req_id_ok && (rd_size != PW'(0)) && rd_on) begin
                        vclip_ff[play_slot] <= id_ff;
                        vpos_ff[play_slot]  <= '0;
                        vgain_ff[play_slot] <= gain_sat;
                        vloop_ff[play_slot] <= flag_ff;
                        if (!free_found) begin
                           rptr_ff <= (rptr_ff == VW'(NUM_VOICES - 1)) ? '0
                                                                       : rptr_ff + VW'(1);
                        end
                     end
                  end
                  OP_STOP: begin
                     ok_ff <= req_id_ok;
                     if (req_id_ok) begin
                        for (int v = 0; v < NUM_VOICES; v++) begin
                           if (vclip_ff[v] == id_ff) begin
                              vclip_ff[v] <= '0;
                              vpos_ff[v]  <= '0;
                              vgain_ff[v] <= GAIN_UNITY;
                              vloop_ff[v] <= 1'b0;
                           end
                        end
                     end
                  end
                  OP_STOP_ALL, OP_RESET: begin
                     ok_ff    <= 1'b1;
                     splay_ff <= 1'b0;
                     rptr_ff  <= '0;
                     for (int v = 0; v < NUM_VOICES; v++) begin
                        vclip_ff[v] <= '0;
                        vpos_ff[v]  <= '0;
                        vgain_ff[v] <= GAIN_UNITY;
                        vloop_ff[v] <= 1'b0;
                     end
                     if (op_ff == OP_RESET) begin
                        son_ff   <= 1'b0;
                        sgain_ff <= GAIN_UNITY;
                        ngain_ff <= NGAIN_MAX;
                        for (int c = 0; c < NUM_CLIPS; c++) begin
                           con_ff[c] <= 1'b0;
                        end
                     end
                  end
                  OP_STRM_EN: begin
                     ok_ff  <= 1'b1;
                     son_ff <= flag_ff;
                     if (!flag_ff) begin
                        splay_ff <= 1'b0;
                     end
                  end
                  OP_STRM_PLAY: begin
                     ok_ff <= son_ff;
                     if (son_ff) begin
                        sgain_ff <= gain_sat;
                        splay_ff <= 1'b1;
                     end
                  end
                  OP_STRM_STOP: begin
                     ok_ff    <= 1'b1;
                     splay_ff <= 1'b0;
                  end
                  default: begin
                     ok_ff <= 1'b0;
                  end
               endcase
            end
            S_MUL: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               acc_ff <= acc_ff + term_ext;
               case (kind_ff)
                  K_NATIVE: begin
                     vidx_ff  <= '0;
                     state_ff <= S_VCHK;
                  end
                  K_VOICE: begin
                     if (vpos_inc == rd_size) begin
                        vpos_ff[vidx_ff] <= '0;
                        if (!vloop_ff[vidx_ff]) begin
                           vclip_ff[vidx_ff] <= '0;
                           vgain_ff[vidx_ff] <= GAIN_UNITY;
                        end
                     end else begin
                        vpos_ff[vidx_ff] <= vpos_inc;
                     end
                     if (vidx_ff == VW'(NUM_VOICES - 1)) begin
                        state_ff <= S_STRM;
                     end else begin
                        vidx_ff  <= vidx_ff + VW'(1);
                        state_ff <= S_VCHK;
                     end
                  end
                  default: begin
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_VCHK: begin
               if (vlive) begin
                  state_ff <= S_VREAD;
               end else begin
                  if (vid != 5'd0) begin
                     vclip_ff[vidx_ff] <= '0;
                     vpos_ff[vidx_ff]  <= '0;
                     vgain_ff[vidx_ff] <= GAIN_UNITY;
                     vloop_ff[vidx_ff] <= 1'b0;
                  end
                  if (vidx_ff == VW'(NUM_VOICES - 1)) begin
                     state_ff <= S_STRM;
                  end else begin
                     vidx_ff <= vidx_ff + VW'(1);
                  end
               end
            end
            S_VREAD: begin
               op_a_ff  <= mem_q_ff;
               op_g_ff  <= vgain_ff[vidx_ff];
               kind_ff  <= K_VOICE;
               state_ff <= S_MUL;
            end
            S_STRM: begin
               if (splay_ff && son_ff && svalid_ff) begin
                  op_a_ff  <= ssample_ff;
                  op_g_ff  <= sgain_ff;
                  kind_ff  <= K_STREAM;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_OUT;
                  if (splay_ff && son_ff) begin
                     splay_ff <= 1'b0;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sample_ff <= (op_ff == OP_MIX) ? sat_sample : 16'sd0;
                  rsp_ok_ff     <= ok_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a command word");

   a_nonzero_mix_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_mixed_sample != 16'sd0)) |-> rsp_accepted)
      else $error("nonzero sample without accept");

   a_rptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(rptr_ff) < NUM_VOICES)
      else $error("replace pointer out of range");

   a_vidx_range: assert property (@(posedge clock) disable iff (reset)
      32'(vidx_ff) < NUM_VOICES)
      else $error("voice index out of range");

   a_stream_play_on: assert property (@(posedge clock) disable iff (reset)
      splay_ff |-> son_ff)
      else $error("stream playing while disabled");
`endif

endmodule

`default_nettype wire

/* hdl/pvm_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// PCM voice mixer scaler
// Shared multiplier: sample magnitude times percent gain, then times the
// reciprocal of 100. Gives the signed, zero-truncated term.
// ----------------------------------------------------------------------------
module pvm_scale (
   input  wire logic                           clock,
   input  wire pvm_pkg::scale_ctl_type         ctl,
   input  wire logic signed [15:0]             sample,
   input  wire logic [7:0]                     gain,
   output logic signed [pvm_pkg::TERM_W-1:0]   term
);
   import pvm_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic              neg_ff;
   logic [16:0]       ext;
   logic [16:0]       mag;
   logic [MAG_W-1:0]  mul_x;
   logic [MAG_W-1:0]  mul_y;
   logic [TERM_W-1:0] quot;

   assign ext   = {sample[15], sample};
   assign mag   = sample[15] ? (~ext + 17'd1) : ext;
   assign mul_x = ctl.recip ? prod_ff[MAG_W-1:0] : MAG_W'(mag);
   assign mul_y = ctl.recip ? RECIP_M : MAG_W'(gain);
   assign quot  = prod_ff[PROD_W-1:RECIP_SHIFT];
   assign term  = neg_ff ? $signed(TERM_W'(0) - quot) : $signed(quot);

   always_ff @(posedge clock) begin
      if (ctl.run) begin
         prod_ff <= PROD_W'(mul_x) * PROD_W'(mul_y);
      end
      if (ctl.run && !ctl.recip) begin
         neg_ff <= sample[15];
      end
   end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// PCM voice mixer testbench
// Drives command words into the mixer and checks each result word against an
// in-bench model of clip memory, voices and the stream. A directed table
// comes first, followed by random traffic with random idle on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import pvm_pkg::*;

   localparam int NCLIPS  = 16;
   localparam int NVOICES = 8;
   localparam int DEPTH   = 4096;
   localparam int NRAND   = 1465;

   typedef struct {
      logic [3:0]         opcode;
      logic signed [15:0] native_sample;
      logic signed [15:0] stream_sample;
      logic               stream_valid;
      logic [4:0]         clip_id;
      logic [11:0]        sample_index;
      logic signed [15:0] clip_sample;
      logic [12:0]        clip_length;
      logic               flag;
      logic [7:0]         gain;
   } word_type;

   typedef struct {
      logic signed [15:0] mixed;
      logic               accepted;
   } result_type;

   // directed row: word, gain write (-1 none), typed expectation if known
   typedef struct {
      word_type   w;
      int         csr;
      bit         known;
      result_type r;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [3:0] req_opcode = '0;
   logic signed [15:0] req_native_sample = '0;
   logic signed [15:0] req_stream_sample = '0;
   logic req_stream_valid = 0;
   logic [4:0] req_clip_id = '0;
   logic [11:0] req_sample_index = '0;
   logic signed [15:0] req_clip_sample = '0;
   logic [12:0] req_clip_length = '0;
   logic req_flag = 0;
   logic [7:0] req_gain = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_mixed_sample;
   logic rsp_accepted;
   logic csr_wen = 0;
   logic [6:0] csr_wdata = '0;

   pcm_voice_mixer DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // mixer state mirror
   logic signed [15:0] clip_mem [NCLIPS*DEPTH];
   logic [12:0] clip_len [NCLIPS];
   bit          clip_en [NCLIPS];
   logic [4:0]  v_clip [NVOICES];
   logic [12:0] v_pos [NVOICES];
   int          v_gain [NVOICES];
   bit          v_loop [NVOICES];
   int          rr_ptr;
   bit          strm_en, strm_play;
   int          strm_gain, ngain;

   result_type expected_q[$];
   int      errors = 0;
   bit      quiet = 0;
   bit      long_hold = 0;

   function automatic void free_voice(int v);
      v_clip[v] = 0; v_pos[v] = 0; v_gain[v] = 100; v_loop[v] = 0;
   endfunction

   function automatic void mixer_reset();
      ngain = 100;
      for (int i = 0; i < NCLIPS; i++) begin
         clip_len[i] = 0; clip_en[i] = 0;
      end
      for (int v = 0; v < NVOICES; v++) free_voice(v);
      rr_ptr = 0; strm_en = 0; strm_play = 0; strm_gain = 100;
   endfunction

   function automatic void stop_every();
      for (int v = 0; v < NVOICES; v++) free_voice(v);
      strm_play = 0; rr_ptr = 0;
   endfunction

   function automatic int sat_gain(logic [7:0] g);
      return (g > GAIN_MAX) ? int'(GAIN_MAX) : int'(g);
   endfunction

   function automatic bit id_ok(logic [4:0] id);
      return id >= 1 && id <= NCLIPS;
   endfunction

   function automatic result_type mix_step(word_type w);
      result_type r;
      int acc, c;
      logic [4:0] id;
      acc = (int'(w.native_sample) * ngain) / 100;
      for (int v = 0; v < NVOICES; v++) begin
         id = v_clip[v];
         if (id == 0) continue;
         c = id - 1;
         if (clip_len[c] == 0 || !clip_en[c] || v_pos[v] >= clip_len[c]) begin
            free_voice(v);
            continue;
         end
         acc += (int'(clip_mem[c*DEPTH + v_pos[v]]) * v_gain[v]) / 100;
         v_pos[v]++;
         if (v_pos[v] == clip_len[c]) begin
            if (v_loop[v]) v_pos[v] = 0;
            else free_voice(v);
         end
      end
      if (strm_play && strm_en) begin
         if (w.stream_valid) acc += (int'(w.stream_sample) * strm_gain) / 100;
         else strm_play = 0;
      end
      if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
      if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
      r.mixed = acc[15:0];
      r.accepted = 1;
      return r;
   endfunction

   function automatic result_type mixer_step(word_type w);
      result_type r;
      int c, slot;
      r.mixed = 0; r.accepted = 0;
      c = id_ok(w.clip_id) ? w.clip_id - 1 : 0;
      case (w.opcode)
         OP_MIX: r = mix_step(w);
         OP_WRITE: if (id_ok(w.clip_id)) begin
            clip_mem[c*DEPTH + w.sample_index] = w.clip_sample;
            r.accepted = 1;
         end
         OP_LENGTH: if (id_ok(w.clip_id) && w.clip_length <= DEPTH) begin
            clip_len[c] = w.clip_length; r.accepted = 1;
         end
         OP_ENABLE: if (id_ok(w.clip_id) && clip_len[c] != 0) begin
            clip_en[c] = w.flag;
            if (!w.flag)
               for (int v = 0; v < NVOICES; v++) if (v_clip[v] == w.clip_id) free_voice(v);
            r.accepted = 1;
         end
         OP_PLAY: if (id_ok(w.clip_id) && clip_len[c] != 0 && clip_en[c]) begin
            slot = -1;
            for (int v = 0; v < NVOICES; v++)
               if (slot < 0 && v_clip[v] == 0) slot = v;
            if (slot < 0) begin
               slot = rr_ptr; rr_ptr = (rr_ptr + 1) % NVOICES;
            end
            v_clip[slot] = w.clip_id; v_pos[slot] = 0;
            v_gain[slot] = sat_gain(w.gain); v_loop[slot] = w.flag;
            r.accepted = 1;
         end
         OP_STOP: if (id_ok(w.clip_id)) begin
            for (int v = 0; v < NVOICES; v++) if (v_clip[v] == w.clip_id) free_voice(v);
            r.accepted = 1;
         end
         OP_STOP_ALL: begin
            stop_every(); r.accepted = 1;
         end
         OP_STRM_EN: begin
            strm_en = w.flag;
            if (!w.flag) strm_play = 0;
            r.accepted = 1;
         end
         OP_STRM_PLAY: if (strm_en) begin
            strm_gain = sat_gain(w.gain); strm_play = 1; r.accepted = 1;
         end
         OP_STRM_STOP: begin
            strm_play = 0; r.accepted = 1;
         end
         OP_RESET: begin
            stop_every();
            for (int i = 0; i < NCLIPS; i++) clip_en[i] = 0;
            strm_en = 0; strm_gain = 100; ngain = 100;
            r.accepted = 1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // every clip in use has its first sixteen samples written up front, so no voice reads unwritten memory
   function automatic word_type blank();
      word_type w;
      w.opcode = OP_MIX; w.native_sample = 0; w.stream_sample = 0; w.stream_valid = 0;
      w.clip_id = 1; w.sample_index = 0; w.clip_sample = 0; w.clip_length = 0;
      w.flag = 0; w.gain = GAIN_UNITY;
      return w;
   endfunction

   function automatic word_type random_word();
      word_type w;
      int k;
      w.native_sample = 16'($urandom); w.stream_sample = 16'($urandom);
      w.stream_valid = ($urandom_range(0, 9) != 0);
      w.clip_id = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 4));
      w.sample_index = 12'($urandom_range(0, 15));
      if ($urandom_range(0, 19) == 0) w.sample_index = 12'($urandom);
      w.clip_sample = 16'($urandom);
      w.clip_length = 13'($urandom_range(0, 16));
      if ($urandom_range(0, 29) == 0) w.clip_length = 13'($urandom);
      w.flag = ($urandom_range(0, 3) != 0);
      w.gain = 8'($urandom);
      k = $urandom_range(0, 99);
      if (k < 45) w.opcode = OP_MIX;
      else if (k < 52) w.opcode = OP_WRITE;
      else if (k < 58) w.opcode = OP_LENGTH;
      else if (k < 65) w.opcode = OP_ENABLE;
      else if (k < 80) w.opcode = OP_PLAY;
      else if (k < 84) w.opcode = OP_STOP;
      else if (k < 86) w.opcode = OP_STOP_ALL;
      else if (k < 90) w.opcode = OP_STRM_EN;
      else if (k < 94) w.opcode = OP_STRM_PLAY;
      else if (k < 96) w.opcode = OP_STRM_STOP;
      else if (k < 97) w.opcode = OP_RESET;
      else w.opcode = 4'($urandom_range(11, 15));
      // a length capped at sixteen never covers a sample beyond those written, keeping memory defined
      if (w.opcode == OP_LENGTH && w.clip_length > 16 && w.clip_length <= DEPTH)
         w.clip_length = 16;
      return w;
   endfunction

   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 7)) @(negedge clock);
   endtask

   task automatic send(word_type w);
      @(negedge clock);
      idle_gap();
      req_opcode <= w.opcode; req_native_sample <= w.native_sample;
      req_stream_sample <= w.stream_sample; req_stream_valid <= w.stream_valid;
      req_clip_id <= w.clip_id; req_sample_index <= w.sample_index;
      req_clip_sample <= w.clip_sample; req_clip_length <= w.clip_length;
      req_flag <= w.flag; req_gain <= w.gain;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(mixer_step(w));
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_gain(int g);
      drain();
      csr_wdata <= g[6:0];
      csr_wen <= 1;
      @(negedge clock);
      csr_wen <= 0;
      if (g[6:0] <= NGAIN_MAX) ngain = g[6:0];
   endtask

   // receiver
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected word: mixed %0d accepted %0d", $time,
                     rsp_mixed_sample, rsp_accepted);
            errors++;
         end else begin
            result_type e;
            e = expected_q.pop_front();
            if (e.mixed !== rsp_mixed_sample) begin
               $display("%0t mixed_sample expected %0d actual %0d", $time, e.mixed,
                        rsp_mixed_sample);
               errors++;
            end
            if (e.accepted !== rsp_accepted) begin
               $display("%0t accepted expected %0d actual %0d", $time, e.accepted,
                        rsp_accepted);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (long_hold) rsp_ready <= 0;
      else if (quiet) rsp_ready <= 1;
      else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         rsp_ready <= 1;
      end else rsp_ready <= 1;
   end

   initial begin
      #10000000;
      $display("pcm_voice_mixer: mismatch");
      $finish;
   end

   initial begin
      row_type dir[$];
      row_type rw;
      word_type w;
      mixer_reset();
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed table
      rw.csr = -1; rw.known = 1;
      w = blank(); w.native_sample = 16'sh7fff;
      rw.w = w; rw.r = '{16'sh7fff, 1}; dir.push_back(rw);
      w = blank(); w.native_sample = -16'sd32768;
      rw.w = w; rw.r = '{-16'sd32768, 1}; dir.push_back(rw);
      w = blank(); w.opcode = OP_WRITE; w.clip_id = 0;
      rw.w = w; rw.r = '{0, 0}; dir.push_back(rw);
      w = blank(); w.opcode = OP_LENGTH; w.clip_id = 17; w.clip_length = 4;
      rw.w = w; rw.r = '{0, 0}; dir.push_back(rw);
      w = blank(); w.opcode = OP_LENGTH; w.clip_length = 13'd4097;
      rw.w = w; rw.r = '{0, 0}; dir.push_back(rw);
      w = blank(); w.opcode = OP_ENABLE; w.flag = 1;
      rw.w = w; rw.r = '{0, 0}; dir.push_back(rw);
      w = blank(); w.opcode = OP_STRM_PLAY;
      rw.w = w; rw.r = '{0, 0}; dir.push_back(rw);
      w = blank(); w.opcode = 4'd15;
      rw.w = w; rw.r = '{0, 0}; dir.push_back(rw);
      w = blank(); w.opcode = OP_WRITE; w.sample_index = 12'hfff; w.clip_sample = 16'sh7fff;
      rw.w = w; rw.r = '{0, 1}; dir.push_back(rw);
      rw.known = 0;
      w = blank(); w.opcode = OP_LENGTH; w.clip_length = 13'd4096;
      rw.w = w; dir.push_back(rw);
      w = blank(); w.opcode = OP_ENABLE; w.flag = 1;
      rw.w = w; dir.push_back(rw);
      w = blank(); w.opcode = OP_STRM_EN; w.flag = 1;
      rw.w = w; dir.push_back(rw);
      w = blank(); w.opcode = OP_STRM_PLAY; w.gain = 8'hff;
      rw.w = w; dir.push_back(rw);
      w = blank(); w.stream_valid = 1; w.stream_sample = -16'sd32768;
      w.native_sample = -16'sd32768; rw.w = w; rw.csr = 0; dir.push_back(rw);
      w = blank(); w.stream_valid = 0; rw.w = w; rw.csr = 101; dir.push_back(rw);
      w = blank(); w.opcode = OP_LENGTH; w.clip_length = 0;
      rw.w = w; rw.csr = 100; dir.push_back(rw);
      w = blank(); w.opcode = OP_STOP; w.clip_id = 16;
      rw.csr = -1; rw.w = w; dir.push_back(rw);
      w = blank(); w.opcode = OP_STOP_ALL; rw.w = w; dir.push_back(rw);
      w = blank(); w.opcode = OP_STRM_STOP; rw.w = w; dir.push_back(rw);
      w = blank(); w.opcode = OP_RESET; rw.csr = 37; rw.w = w; dir.push_back(rw);
      w = blank(); w.native_sample = 16'sd12345; rw.csr = -1; rw.w = w; dir.push_back(rw);

      foreach (dir[i]) begin
         if (dir[i].csr >= 0) write_gain(dir[i].csr);
         if (dir[i].known) begin
            result_type got;
            send(dir[i].w);
            got = expected_q[$];
            if (got.mixed !== dir[i].r.mixed || got.accepted !== dir[i].r.accepted) begin
               $display("%0t table row %0d expected %0d/%0d actual %0d/%0d", $time, i,
                        dir[i].r.mixed, dir[i].r.accepted, got.mixed, got.accepted);
               errors++;
            end
         end else send(dir[i].w);
      end

      // fill the first sixteen samples of the first four clips so random play never reads unwritten data
      for (int c = 1; c <= 4; c++)
         for (int s = 0; s < 16; s++) begin
            w = blank(); w.opcode = OP_WRITE; w.clip_id = 5'(c); w.sample_index = 12'(s);
            w.clip_sample = 16'($urandom);
            send(w);
         end

      for (int n = 0; n < NRAND; n++) begin
         if (n == 300) begin
            fork
               begin
                  long_hold = 1;
                  repeat (200) @(negedge clock);
                  long_hold = 0;
               end
            join_none
         end
         if (n % 400 == 399) write_gain($urandom_range(0, 127));
         if (n == NRAND - 200) quiet = 1;
         w = random_word();
         if (w.opcode == OP_WRITE && !(id_ok(w.clip_id) && w.clip_id <= 4 && w.sample_index < 16))
            w.sample_index = 12'($urandom_range(0, 15));
         if (w.opcode == OP_LENGTH && id_ok(w.clip_id) && w.clip_id > 4 && w.clip_length <= DEPTH)
            w.clip_length = 0;
         if (w.opcode == OP_LENGTH && w.clip_id == 1 && w.clip_length > 16 && w.clip_length <= DEPTH)
            w.clip_length = 16;
         send(w);
      end

      drain();
      if (errors == 0) $display("pcm_voice_mixer: match");
      else $display("pcm_voice_mixer: mismatch");
      $finish;
   end
endmodule

/* sim.f */
hdl/pvm_pkg.sv
hdl/pvm_scale.sv
hdl/pcm_voice_mixer.sv
bench/tb_top.sv
